>>> rtl/core/periodic_tick_with_oneshot_alarm_macros.svh
// Assertion macros shared by the checker of the tick and alarm block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef PERIODIC_TICK_WITH_ONESHOT_ALARM_MACROS_SVH
`define PERIODIC_TICK_WITH_ONESHOT_ALARM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTOA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/ptoa_pkg.sv
`default_nettype none

package ptoa_pkg;

    // Command codes of an input request.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ARM  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RELOAD = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [15:0] RELOAD_RESET = 16'd100;
    localparam logic [19:0] PERIOD_RESET = 20'd10000;

    // Step counts of the shared divide and multiply unit.
    localparam int DIV_STEPS = 32;
    localparam int MUL_STEPS = 20;

    // Alarm mode relative to the current period.
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_WITHIN = 2'd1,
        MODE_EXACT  = 2'd2,
        MODE_BEYOND = 2'd3
    } t_mode;

    // One input request.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] delay_us;
        logic [19:0] fine_offset_us;
    } t_req;

    // One result.
    typedef struct packed {
        logic [31:0] elapsed_us;
        logic        clock_event;
        logic        period_event;
    } t_rsp;

endpackage

`default_nettype wire

>>> rtl/core/periodic_tick_with_oneshot_alarm.sv
// Tick: the result is held in r_res and moves to the output register once that is free.
// Arm: 32 divide steps in the serial divider, then the ADJ and CLS states.
// Read: the RADJ and RSUB states, then 20 multiply steps in the serial multiplier.
// One request at a time; the next is taken in the cycle after the result is registered,
// so no new request is taken while the last one is still being worked on.
// Synchronous active-low reset: reload 100 ticks, period 10000 us, alarm off.
`default_nettype none

module periodic_tick_with_oneshot_alarm (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire ptoa_pkg::t_req  i_in_req,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output ptoa_pkg::t_rsp       o_out_rsp,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [19:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADJ,
        S_CLS,
        S_RADJ,
        S_RSUB,
        S_MUL,
        S_DONE
    } t_state;

    localparam int CNT_W = $clog2(ptoa_pkg::DIV_STEPS);

    t_state          r_state;
    ptoa_pkg::t_mode r_mode;
    logic [15:0]     r_reload;
    logic [19:0]     r_period;
    logic [31:0]     r_cd;
    logic [31:0]     r_rem;
    logic [31:0]     r_quo;
    logic [19:0]     r_drem;
    logic [31:0]     r_acc;
    logic [31:0]     r_mcand;
    logic [19:0]     r_mplier;
    logic [CNT_W-1:0] r_cnt;
    ptoa_pkg::t_rsp  r_res;
    logic            r_out_valid;
    ptoa_pkg::t_rsp  r_out;

    logic [31:0] alu_a;
    logic [31:0] alu_b;
    logic        alu_cin;
    logic [32:0] alu_sum;
    logic        in_take;
    logic        out_free;
    logic [31:0] reload_ext;
    logic        tick_due;
    logic        ev_clock;
    logic        ev_period;

    assign in_take     = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign reload_ext  = {16'd0, r_reload};
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;

    // Events that a tick raises when the countdown expires.
    assign tick_due  = (r_cd <= 32'd1);
    assign ev_clock  = tick_due && ((r_mode == ptoa_pkg::MODE_WITHIN) ||
                                    (r_mode == ptoa_pkg::MODE_EXACT));
    assign ev_period = tick_due && (r_mode != ptoa_pkg::MODE_WITHIN);

    // Shared adder: trial subtract while dividing, accumulate while multiplying.
    always_comb begin
        case (r_state)
            S_DIV: begin
                alu_a   = {11'd0, r_drem, r_quo[31]};
                alu_b   = ~{12'd0, r_period};
                alu_cin = 1'b1;
            end
            S_MUL: begin
                alu_a   = r_acc;
                alu_b   = r_mplier[0] ? r_mcand : 32'd0;
                alu_cin = 1'b0;
            end
            default: begin
                alu_a   = 32'd0;
                alu_b   = 32'd0;
                alu_cin = 1'b0;
            end
        endcase
        alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {32'd0, alu_cin};
    end

    // Sequencer, alarm state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= ptoa_pkg::MODE_OFF;
            r_reload    <= ptoa_pkg::RELOAD_RESET;
            r_period    <= ptoa_pkg::PERIOD_RESET;
            r_cd        <= {16'd0, ptoa_pkg::RELOAD_RESET};
            r_rem       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            // The user must send configuration writes only while the block is idle; the block does not enforce this.
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ptoa_pkg::CFG_RELOAD: r_reload <= i_cfg_data[15:0];
                    ptoa_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                    default: ;
                endcase
            end

            // The output register loads a finished result and empties when it is taken.
            if ((r_state == S_DONE) && out_free) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        case (i_in_req.command)
                            ptoa_pkg::CMD_TICK: begin
                                r_res   <= {32'd0, ev_clock, ev_period};
                                r_state <= S_DONE;
                                if (r_cd > 32'd1) begin
                                    r_cd <= r_cd - 32'd1;
                                end else begin
                                    // Expiry: act on the alarm mode.
                                    case (r_mode)
                                        ptoa_pkg::MODE_WITHIN: begin
                                            r_cd   <= r_rem;
                                            r_mode <= ptoa_pkg::MODE_OFF;
                                        end
                                        ptoa_pkg::MODE_EXACT: begin
                                            r_cd   <= reload_ext;
                                            r_mode <= ptoa_pkg::MODE_OFF;
                                        end
                                        ptoa_pkg::MODE_BEYOND: begin
                                            if (r_rem < reload_ext) begin
                                                r_cd   <= r_rem;
                                                r_rem  <= reload_ext - r_rem;
                                                r_mode <= ptoa_pkg::MODE_WITHIN;
                                            end else if (r_rem == reload_ext) begin
                                                r_cd   <= reload_ext;
                                                r_mode <= ptoa_pkg::MODE_EXACT;
                                            end else begin
                                                r_cd  <= reload_ext;
                                                r_rem <= r_rem - reload_ext;
                                            end
                                        end
                                        default: begin
                                            r_cd <= reload_ext;
                                        end
                                    endcase
                                end
                            end
                            ptoa_pkg::CMD_ARM: begin
                                r_res   <= '0;
                                r_quo   <= i_in_req.delay_us;
                                r_drem  <= 20'd0;
                                r_cnt   <= CNT_W'(ptoa_pkg::DIV_STEPS - 1);
                                r_state <= S_DIV;
                            end
                            ptoa_pkg::CMD_READ: begin
                                r_res   <= '0;
                                r_acc   <= {12'd0, i_in_req.fine_offset_us};
                                r_state <= S_RADJ;
                            end
                            default: begin
                                r_res   <= '0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end

                // One restoring divide step per cycle, quotient shifts in from the right.
                S_DIV: begin
                    if (alu_sum[32]) begin
                        r_drem <= alu_sum[19:0];
                    end else begin
                        r_drem <= {r_drem[18:0], r_quo[31]};
                    end
                    r_quo <= {r_quo[30:0], alu_sum[32]};
                    if (r_cnt == '0) begin
                        r_state <= S_ADJ;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end

                // Fold a pending remainder back in and form the saturated tick count.
                S_ADJ: begin
                    if (r_mode == ptoa_pkg::MODE_WITHIN) begin
                        r_cd <= r_cd + r_rem;
                    end
                    if (r_quo != 32'hFFFF_FFFF) begin
                        r_quo <= r_quo + 32'd1;
                    end
                    r_state <= S_CLS;
                end

                // Classify the alarm against the ticks left in this period.
                S_CLS: begin
                    if (r_quo < r_cd) begin
                        r_rem  <= r_cd - r_quo;
                        r_cd   <= r_quo;
                        r_mode <= ptoa_pkg::MODE_WITHIN;
                    end else if (r_quo > r_cd) begin
                        r_rem  <= r_quo - r_cd;
                        r_mode <= ptoa_pkg::MODE_BEYOND;
                    end else begin
                        r_mode <= ptoa_pkg::MODE_EXACT;
                    end
                    r_state <= S_DONE;
                end

                // Ticks left to the period end, alarm split included.
                S_RADJ: begin
                    r_mcand <= (r_mode == ptoa_pkg::MODE_WITHIN) ? (r_cd + r_rem) : r_cd;
                    r_state <= S_RSUB;
                end

                S_RSUB: begin
                    r_mcand  <= reload_ext - r_mcand;
                    r_mplier <= r_period;
                    r_cnt    <= CNT_W'(ptoa_pkg::MUL_STEPS - 1);
                    r_state  <= S_MUL;
                end

                // One shift-add multiply step per cycle, modulo 2^32.
                S_MUL: begin
                    r_acc    <= alu_sum[31:0];
                    r_mcand  <= {r_mcand[30:0], 1'b0};
                    r_mplier <= {1'b0, r_mplier[19:1]};
                    if (r_cnt == '0) begin
                        r_res.elapsed_us <= alu_sum[31:0];
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end

                // Hand the result over once the output register is free.
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ptoa_checker.sv
`default_nettype none
`include "periodic_tick_with_oneshot_alarm_macros.svh"

module ptoa_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire ptoa_pkg::t_rsp o_out_rsp,
    input wire logic           i_cfg_valid,
    input wire logic           o_cfg_ready
);

    logic out_held;
    logic out_event;
    logic in_took;

    assign out_held  = o_out_valid && i_out_stall;
    assign out_event = o_out_valid && (o_out_rsp.clock_event || o_out_rsp.period_event);
    assign in_took   = i_in_valid && !o_in_stall;

    // A stalled result stays valid and unchanged.
    `PTOA_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out_rsp), "result moved")

    // A tick result carries events only, never an elapsed time.
    `PTOA_ASSERT_SAME(a_event_no_time, out_event, o_out_rsp.elapsed_us == 32'd0, "event with time")

    // The block works on one request at a time.
    `PTOA_ASSERT_NEXT(a_busy_after_take, in_took, o_in_stall, "request taken while busy")

    // Configuration writes are always accepted.
    `PTOA_ASSERT_SAME(a_cfg_ready, i_cfg_valid, o_cfg_ready, "configuration write refused")

endmodule

bind periodic_tick_with_oneshot_alarm ptoa_checker u_ptoa_checker (.*);

`default_nettype wire
